/* hw/rtl/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern search unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 32;
  localparam int unsigned OFFSET_BITS_DEF       = 32;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned PAT_BYTES = 32;              // bytes held in the pattern regs
  localparam int unsigned PAT_W     = 8 * PAT_BYTES;
  localparam int unsigned PAT_IDX_W = $clog2(PAT_BYTES);
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned APB_AW    = 6;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned REG_IDX_W = 3;

  // register indexes, byte address = 8 * index
  localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MASK = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BASE = 3'd6;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_word_t;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [MASK_W-1:0] mask;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] base;
  } cfg_t;

  typedef struct packed {
    logic shift;   // word accepted, move bytes one cell along
    logic clear;   // end of region, window back to zero
  } cell_ctrl_t;

endpackage

/* hw/rtl/mbps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// APB register file: pattern bytes, compare mask, length and base address.
// ----------------------------------------------------------------------------
module mbps_cfg_regs import mbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [PAT_W-1:0]     pat_q;
  logic [MASK_W-1:0]    mask_q;
  logic [LEN_W-1:0]     len_q;
  logic [ADDR_W-1:0]    base_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:3];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      mask_q <= '0;
      len_q  <= LEN_RESET;
      base_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PAT0: pat_q[0*APB_DW +: APB_DW] <= pwdata;
        REG_PAT1: pat_q[1*APB_DW +: APB_DW] <= pwdata;
        REG_PAT2: pat_q[2*APB_DW +: APB_DW] <= pwdata;
        REG_PAT3: pat_q[3*APB_DW +: APB_DW] <= pwdata;
        REG_MASK: mask_q <= pwdata[MASK_W-1:0];
        REG_LEN:  len_q  <= pwdata[LEN_W-1:0];
        REG_BASE: base_q <= pwdata[ADDR_W-1:0];
        default: ;  // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAT0: prdata = pat_q[0*APB_DW +: APB_DW];
      REG_PAT1: prdata = pat_q[1*APB_DW +: APB_DW];
      REG_PAT2: prdata = pat_q[2*APB_DW +: APB_DW];
      REG_PAT3: prdata = pat_q[3*APB_DW +: APB_DW];
      REG_MASK: prdata = {{(APB_DW-MASK_W){1'b0}}, mask_q};
      REG_LEN:  prdata = {{(APB_DW-LEN_W){1'b0}}, len_q};
      REG_BASE: prdata = {{(APB_DW-ADDR_W){1'b0}}, base_q};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = '{pattern: pat_q, mask: mask_q, len: len_q, base: base_q};

endmodule

/* hw/rtl/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it on, and checks the byte
// entering it against the pattern byte that lines up with this position.
// ----------------------------------------------------------------------------
module mbps_cell import mbps_pkg::*; #(
  parameter int unsigned POS = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [7:0]        byte_i,     // byte that lands here on this shift
  input  logic [LEN_W-1:0]  len_i,      // clamped pattern length
  input  logic [PAT_W-1:0]  pattern_i,
  input  logic [MASK_W-1:0] mask_i,
  output logic [7:0]        byte_o,
  output logic              ok_o
);

  localparam logic [LEN_W-1:0] POS_L = LEN_W'(POS);

  logic [7:0]           byte_q;
  logic [LEN_W-1:0]     rel;
  logic [PAT_IDX_W-1:0] sel;
  logic                 active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  // position POS after the shift pairs with pattern byte len-1-POS
  assign rel    = len_i - POS_L - LEN_W'(1);
  assign sel    = rel[PAT_IDX_W-1:0];
  assign active = POS_L < len_i;
  assign ok_o   = !active || !mask_i[sel] || (pattern_i[sel*8 +: 8] == byte_i);
  assign byte_o = byte_q;

endmodule

/* hw/rtl/masked_byte_pattern_search_unit.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_unit
// Scans a byte stream for the first match of a masked pattern of up to 32
// bytes and reports its address, or not found at the end of the region.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock with no bubbles: every byte is accepted
// in the cycle it is offered unless a second undelivered result is waiting.
// Each byte enters a row of MAX_PATTERN_BYTES cells that shifts every accepted
// word; all cells compare in the same cycle, so the match decision and the
// address add (base plus start offset) happen in the accept cycle; the result
// is registered in the output register or skid buffer. At most one result word
// is produced per region: found=1 on the byte completing the first match
// (even if it is the last byte), or found=0 with a zero address on the last
// byte when nothing matched. An output register plus a one-word skid buffer
// decouples the sides, so input is stalled only when both hold a word.
// Compare-mask bits at or above the pattern length are ignored; a length of
// zero matches at offset 0; a length above MAX_PATTERN_BYTES is clamped. The
// offset counter is OFFSET_BITS wide and saturates; bytes arriving while it
// is saturated cannot complete a match. Registers sit at byte addresses 8*i
// on the APB port and should be written only between regions or while the
// stream is idle; changes apply from the next byte, window content is kept.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_unit import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS       = OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte stream
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  // results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [LEN_W-1:0]       MAX_LEN  = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [OFFSET_BITS-1:0] SEEN_MAX = '1;

  cfg_t                    cfg;
  cell_ctrl_t              cell_ctrl;
  logic [LEN_W-1:0]        len_eff;
  logic [7:0]              chain [MAX_PATTERN_BYTES+1];  // chain[k] feeds cell k
  logic [MAX_PATTERN_BYTES-1:0] ok_vec;

  logic                    in_accept;
  logic                    out_pop;
  logic [OFFSET_BITS-1:0]  seen_q, seen_d;
  logic                    matched_q, matched_d;
  logic [OFFSET_BITS:0]    seen_p1;
  logic [OFFSET_BITS-1:0]  start;
  logic                    count_ok;
  logic                    hit;
  logic                    res_valid;
  out_word_t               res;

  logic                    out_valid_q, skid_valid_q;
  out_word_t               out_q, skid_q;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  mbps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign len_eff = (cfg.len > MAX_LEN) ? MAX_LEN : cfg.len;

  // --------------------------------------------------------------------------
  // window: row of cells, newest byte in cell 0
  // --------------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;
  assign cell_ctrl = '{shift: in_accept, clear: in_word_i.last_byte};
  assign chain[0]  = in_word_i.data_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    mbps_cell #(.POS(k)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .byte_i    (chain[k]),
      .len_i     (len_eff),
      .pattern_i (cfg.pattern),
      .mask_i    (cfg.mask),
      .byte_o    (chain[k+1]),
      .ok_o      (ok_vec[k])
    );
  end

  // --------------------------------------------------------------------------
  // match decision and region bookkeeping
  // --------------------------------------------------------------------------
  assign seen_p1  = {1'b0, seen_q} + (OFFSET_BITS+1)'(1);
  // enough bytes in this region to cover the whole pattern
  assign count_ok = seen_p1 >= (OFFSET_BITS+1)'(len_eff);
  assign start    = (len_eff == '0) ? seen_q
                  : OFFSET_BITS'(seen_p1 - (OFFSET_BITS+1)'(len_eff));
  assign hit      = in_accept && !matched_q && (seen_q != SEEN_MAX) &&
                    ((len_eff == '0) || (count_ok && (&ok_vec)));

  // one word per region: the first hit, or not-found on the last byte
  assign res_valid = hit || (in_accept && in_word_i.last_byte && !matched_q);
  assign res.found = hit;
  assign res.match_address = hit ? (cfg.base + ADDR_W'(start)) : '0;

  always_comb begin
    seen_d    = seen_q;
    matched_d = matched_q;
    if (in_accept) begin
      if (in_word_i.last_byte) begin
        seen_d    = '0;
        matched_d = 1'b0;
      end else begin
        seen_d    = (seen_q == SEEN_MAX) ? seen_q : seen_p1[OFFSET_BITS-1:0];
        matched_d = matched_q | hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      matched_q <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      matched_q <= matched_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register with one-word skid
  // --------------------------------------------------------------------------
  assign out_pop    = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is stalled, drain skid into output
      if (out_pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_pop) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (!out_valid_q || out_pop) begin
      out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.found) |-> (out_word_o.match_address == '0))
    else $error("not-found word carries a nonzero address");

  a_region_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_word_i.last_byte) |=> (seen_q == '0 && !matched_q))
    else $error("region state not cleared after last byte");

  a_matched_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !in_word_i.last_byte && matched_q) |=> matched_q)
    else $error("match flag dropped inside a region");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q |-> !hit)
    else $error("second match reported in one region");

endmodule
